[hw/rtl/spmv_pkg.sv]
// ----------------------------------------------------------------------------
// spmv_pkg
// Types and constants shared by the scaled CSR sparse matrix-vector multiply.
// ----------------------------------------------------------------------------
package spmv_pkg;

   // Command codes of the request channel.
   localparam logic [1:0] CMD_LOAD      = 2'd0;
   localparam logic [1:0] CMD_NONZERO   = 2'd1;
   localparam logic [1:0] CMD_EMPTY_ROW = 2'd2;

   // Configuration register indexes.
   localparam int         CSR_INDEX_WIDTH = 4;
   localparam logic [3:0] CSR_ALPHA       = 4'd0;
   localparam logic [3:0] CSR_BETA        = 4'd1;

   // Depth of the queue between the front and the back part.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0]         command;
      logic [9:0]         column;
      logic signed [31:0] value;
      logic               row_end;
      logic signed [31:0] b_old;
   } req_type;

   typedef struct packed {
      logic signed [31:0] b_new;
      logic [15:0]        row_index;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] alpha;
      logic signed [31:0] beta;
   } gains_type;

   // Work kinds that the front part hands to the back part.
   typedef enum logic [1:0] {
      OP_RESTART  = 2'd0,
      OP_MAC      = 2'd1,
      OP_MAC_EMIT = 2'd2,
      OP_EMIT     = 2'd3
   } op_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] value;
      logic signed [31:0] x;
      logic signed [31:0] b_old;
   } entry_type;

   typedef enum logic [2:0] {
      ST_RUN   = 3'd0,
      ST_LAST  = 3'd1,
      ST_LO    = 3'd2,
      ST_HI    = 3'd3,
      ST_BETA  = 3'd4,
      ST_ALPHA = 3'd5,
      ST_SUM   = 3'd6
   } state_type;

endpackage

[hw/rtl/spmv_ram.sv]
// ----------------------------------------------------------------------------
// spmv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spmv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/spmv_front.sv]
// ----------------------------------------------------------------------------
// spmv_front
// Accepts request transactions, keeps the x store and classifies each command
// into a work entry for the back part.
// ----------------------------------------------------------------------------
module spmv_front #(
   parameter int VEC_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  spmv_pkg::req_type                   req_data,
   output logic                                req_full,
   input  logic [spmv_pkg::QUEUE_CNT_W-1:0]    q_count,
   output logic                                q_push,
   output spmv_pkg::entry_type                 q_entry
);
   import spmv_pkg::*;

   localparam int AW = $clog2(VEC_DEPTH);

   logic                 accept;
   logic                 col_ok;
   logic [AW-1:0]        addr;
   logic [QUEUE_CNT_W:0] pending;
   logic                 ram_wr;
   logic                 ram_rd;
   logic [31:0]          ram_q;

   logic               s1_valid_ff, s1_valid_in;
   op_type             s1_op_ff, s1_op_in;
   logic signed [31:0] s1_value_ff;
   logic signed [31:0] s1_bold_ff;
   logic               s1_colok_ff;

   // The item in the capture stage always moves into the queue next cycle,
   // so it is counted as already queued.
   assign pending  = {1'b0, q_count} + (QUEUE_CNT_W + 1)'(s1_valid_ff);
   assign req_full = pending >= (QUEUE_CNT_W + 1)'(QUEUE_DEPTH);
   assign accept   = req_push && !req_full;

   assign col_ok = 32'(req_data.column) < 32'(VEC_DEPTH);
   assign addr   = AW'(req_data.column);

   always_comb begin
      s1_valid_in = 1'b0;
      s1_op_in    = OP_EMIT;
      ram_wr      = 1'b0;
      ram_rd      = 1'b0;
      if (accept) begin
         case (req_data.command)
            CMD_LOAD: begin
               s1_valid_in = 1'b1;
               s1_op_in    = OP_RESTART;
               ram_wr      = col_ok;
            end
            CMD_NONZERO: begin
               s1_valid_in = 1'b1;
               s1_op_in    = req_data.row_end ? OP_MAC_EMIT : OP_MAC;
               ram_rd      = 1'b1;
            end
            CMD_EMPTY_ROW: begin
               s1_valid_in = 1'b1;
               s1_op_in    = OP_EMIT;
            end
            default: begin
               s1_valid_in = 1'b0;
            end
         endcase
      end
   end

   spmv_ram #(
      .WIDTH (32),
      .DEPTH (VEC_DEPTH)
   ) u_x_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (addr),
      .wr_data (req_data.value),
      .rd_en   (ram_rd),
      .rd_addr (addr),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_op_ff    <= s1_op_in;
      s1_value_ff <= req_data.value;
      s1_bold_ff  <= req_data.b_old;
      s1_colok_ff <= col_ok;
   end

   // A column beyond the store reads as zero.
   assign q_push        = s1_valid_ff;
   assign q_entry.op    = s1_op_ff;
   assign q_entry.value = s1_value_ff;
   assign q_entry.x     = s1_colok_ff ? $signed(ram_q) : 32'sd0;
   assign q_entry.b_old = s1_bold_ff;

endmodule

[hw/rtl/spmv_queue.sv]
// ----------------------------------------------------------------------------
// spmv_queue
// Short work queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module spmv_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  spmv_pkg::entry_type              push_data,
   input  logic                             pop,
   output spmv_pkg::entry_type              head,
   output logic [spmv_pkg::QUEUE_CNT_W-1:0] count
);
   import spmv_pkg::*;

   entry_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? QUEUE_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QUEUE_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QUEUE_CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QUEUE_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

[hw/rtl/spmv_back.sv]
// ----------------------------------------------------------------------------
// spmv_back
// Executes work entries: multiply-accumulate of nonzeros, row result
// sequencing on one shared 32x32 multiplier, and the result register.
// ----------------------------------------------------------------------------
module spmv_back #(
   parameter int MAX_ROWS  = 65536,
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  spmv_pkg::gains_type   gains,
   input  logic                  q_valid,
   input  spmv_pkg::entry_type   q_head,
   output logic                  q_pop,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output spmv_pkg::rsp_type     rsp_data
);
   import spmv_pkg::*;

   localparam logic [63:0] HALF      = (64'd1 << FRAC_BITS) >> 1;
   localparam int          ROW_CAP   = (MAX_ROWS > 65536) ? 65536 : MAX_ROWS;
   localparam logic [15:0] ROW_LIMIT = 16'(ROW_CAP - 1);
   localparam logic [63:0] POS_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_MAG   = 64'h8000_0000_0000_0000;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic [63:0] mag64(input logic [63:0] v);
      mag64 = v[63] ? (~v + 64'd1) : v;
   endfunction

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (!a[63] && !b[63] && s[63]) begin
         sat_add64 = POS_MAX;
      end else if (a[63] && b[63] && !s[63]) begin
         sat_add64 = NEG_MAG;
      end else begin
         sat_add64 = s;
      end
   endfunction

   state_type state_ff, state_in;

   logic [31:0] mul_a, mul_b;
   logic        emit_write;
   logic        slot_free;
   logic        head_mac;
   logic        head_emit;

   logic [63:0] mul_ff, mul_in;
   logic        prod_valid_ff, prod_valid_in;
   logic        prod_neg_ff, prod_neg_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] bold_ff, bold_in;
   logic [63:0] lo_ff, lo_in;
   logic [95:0] sum96_ff, sum96_in;
   logic [63:0] am_ff, am_in;
   logic [63:0] bt_ff, bt_in;
   logic [15:0] row_ff, row_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_data_ff, out_data_in;

   logic [63:0] mul_round;
   logic [63:0] mul_term;
   logic [63:0] acc_mag;
   logic        neg_alpha;
   logic        neg_beta;
   logic [96:0] wide_round;
   logic [63:0] alpha_limit;
   logic        alpha_over;
   logic [63:0] alpha_mag;
   logic [63:0] total;
   logic [31:0] total_clamped;

   assign head_mac  = (q_head.op == OP_MAC) || (q_head.op == OP_MAC_EMIT);
   assign head_emit = (q_head.op == OP_MAC_EMIT) || (q_head.op == OP_EMIT);
   assign slot_free = !out_valid_ff || rsp_pop;
   assign acc_mag   = mag64(acc_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN: begin
            if (q_valid && head_emit) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST:  state_in = ST_LO;
         ST_LO:    state_in = ST_HI;
         ST_HI:    state_in = ST_BETA;
         ST_BETA:  state_in = ST_ALPHA;
         ST_ALPHA: state_in = ST_SUM;
         ST_SUM: begin
            if (slot_free) begin
               state_in = ST_RUN;
            end
         end
         default:  state_in = ST_RUN;
      endcase
   end

   // Sequencer outputs: queue pop and operand selection of the multiplier.
   always_comb begin
      q_pop      = 1'b0;
      emit_write = 1'b0;
      mul_a      = 32'd0;
      mul_b      = 32'd0;
      case (state_ff)
         ST_RUN: begin
            q_pop = q_valid;
            mul_a = mag32(q_head.value);
            mul_b = mag32(q_head.x);
         end
         ST_LO: begin
            mul_a = acc_mag[31:0];
            mul_b = mag32(gains.alpha);
         end
         ST_HI: begin
            mul_a = acc_mag[63:32];
            mul_b = mag32(gains.alpha);
         end
         ST_BETA: begin
            mul_a = mag32(bold_ff);
            mul_b = mag32(gains.beta);
         end
         ST_SUM: begin
            emit_write = slot_free;
         end
         default: begin
            mul_a = 32'd0;
         end
      endcase
   end

   // Rounding of a product magnitude, half away from zero.
   assign mul_round = (mul_ff + HALF) >> FRAC_BITS;
   assign mul_term  = prod_neg_ff ? (~mul_round + 64'd1) : mul_round;

   // alpha times the row sum: round, shift and saturate the 96-bit product.
   assign neg_alpha   = gains.alpha[31] ^ acc_ff[63];
   assign neg_beta    = gains.beta[31] ^ bold_ff[31];
   assign wide_round  = ({1'b0, sum96_ff} + 97'(HALF)) >> FRAC_BITS;
   assign alpha_limit = neg_alpha ? NEG_MAG : POS_MAX;
   assign alpha_over  = (|wide_round[96:64]) || (wide_round[63:0] > alpha_limit);
   assign alpha_mag   = alpha_over ? alpha_limit : wide_round[63:0];

   assign total = sat_add64(am_ff, bt_ff);

   always_comb begin
      if (!total[63] && (total[63:31] != 33'd0)) begin
         total_clamped = 32'h7FFF_FFFF;
      end else if (total[63] && (total[63:31] != {33{1'b1}})) begin
         total_clamped = 32'h8000_0000;
      end else begin
         total_clamped = total[31:0];
      end
   end

   always_comb begin
      mul_in        = mul_a * mul_b;
      prod_valid_in = q_pop && head_mac;
      prod_neg_in   = q_head.value[31] ^ q_head.x[31];
      bold_in       = q_pop ? q_head.b_old : bold_ff;
      lo_in         = (state_ff == ST_HI) ? mul_ff : lo_ff;
      sum96_in      = (state_ff == ST_BETA) ? ({32'd0, lo_ff} + {mul_ff, 32'd0}) : sum96_ff;
      am_in         = am_ff;
      bt_in         = bt_ff;
      if (state_ff == ST_ALPHA) begin
         am_in = neg_alpha ? (~alpha_mag + 64'd1) : alpha_mag;
         bt_in = neg_beta ? (~mul_round + 64'd1) : mul_round;
      end

      acc_in = acc_ff;
      if (emit_write) begin
         acc_in = 64'd0;
      end else if (prod_valid_ff) begin
         acc_in = sat_add64(acc_ff, mul_term);
      end

      row_in = row_ff;
      if (q_pop && (q_head.op == OP_RESTART)) begin
         row_in = 16'd0;
      end else if (emit_write && (row_ff < ROW_LIMIT)) begin
         row_in = row_ff + 16'd1;
      end

      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (emit_write) begin
         out_valid_in          = 1'b1;
         out_data_in.b_new     = $signed(total_clamped);
         out_data_in.row_index = row_ff;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         prod_valid_ff <= 1'b0;
         acc_ff        <= 64'd0;
         row_ff        <= 16'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prod_valid_ff <= prod_valid_in;
         acc_ff        <= acc_in;
         row_ff        <= row_in;
         out_valid_ff  <= out_valid_in;
      end
      mul_ff      <= mul_in;
      prod_neg_ff <= prod_neg_in;
      bold_ff     <= bold_in;
      lo_ff       <= lo_in;
      sum96_ff    <= sum96_in;
      am_ff       <= am_in;
      bt_ff       <= bt_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[hw/rtl/csr_sparse_matrix_vector_multiply.sv]
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply
// Computes b = alpha*A*x + beta*b for a CSR matrix in signed Q16.16 fixed point.
// Requests are pushed like a queue (req_push, req_full) and results are popped
// like a queue (rsp_empty, rsp_pop); the gains are written on the csr_ channel,
// which is always ready. A load transaction stores one x entry and restarts the
// row count, a nonzero transaction multiply-accumulates value times x[column],
// and a row-end nonzero or an empty-row transaction makes one row result.
// Loads and nonzeros flow at one transaction per cycle while the back part is
// not busy on a row result or held by the receiver. The row result is made on
// one shared 32x32 multiplier in the back-part steps LAST, LO, HI, BETA, ALPHA
// and SUM, during which the back part takes no new work entry.
// Reset clears the queues, the accumulator and the row count and sets alpha to
// 1.0 and beta to 0; the x store is not cleared and must be loaded before use.
// When the receiver stalls, the result waits in the output register, the back
// part holds in its last step, and the front keeps accepting until its queue
// of four entries fills and req_full rises.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply #(
   parameter int VEC_DEPTH = 1024,
   parameter int MAX_ROWS  = 65536,
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   input  spmv_pkg::req_type                    req_data,
   output logic                                 req_full,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output spmv_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [spmv_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                          csr_data
);
   import spmv_pkg::*;

   // Gain registers. Writes to an index past the list are dropped.
   gains_type gains_ff, gains_in;

   always_comb begin
      gains_in = gains_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ALPHA: gains_in.alpha = $signed(csr_data);
            CSR_BETA:  gains_in.beta  = $signed(csr_data);
            default:   gains_in       = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.alpha <= 32'sh0001_0000;
         gains_ff.beta  <= 32'sh0000_0000;
      end else begin
         gains_ff <= gains_in;
      end
   end

   assign csr_ready = 1'b1;

   // Front part: request acceptance, x store and command classification.
   logic                   q_push;
   entry_type              q_entry;
   logic                   q_pop;
   entry_type              q_head;
   logic [QUEUE_CNT_W-1:0] q_count;
   logic                   q_valid;

   spmv_front #(
      .VEC_DEPTH (VEC_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_count  (q_count),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   // The work queue lets the front keep taking transactions while the back
   // part is busy on a row result or waiting on the receiver.
   spmv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_entry),
      .pop       (q_pop),
      .head      (q_head),
      .count     (q_count)
   );

   assign q_valid = q_count != '0;

   // Back part: accumulation, row result sequencing and the result register.
   spmv_back #(
      .MAX_ROWS  (MAX_ROWS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .gains     (gains_ff),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

[hw/rtl/spmv_checker.sv]
// ----------------------------------------------------------------------------
// spmv_checker
// Port-level checks of the sparse matrix-vector multiply, bound to the top.
// ----------------------------------------------------------------------------
module spmv_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input spmv_pkg::rsp_type rsp_data
);

   // Reset leaves no result behind.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result visible right after reset");

   // Reset leaves the request side open.
   a_reset_open: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request side full right after reset");

   // A waiting result is neither lost nor altered while the receiver stalls.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled result changed or vanished");

endmodule

bind csr_sparse_matrix_vector_multiply spmv_checker u_checker (.*);

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the scaled CSR sparse matrix-vector multiply.
// Loads, nonzeros and empty rows are pushed with random gaps while results are
// popped with random stalls. A scoreboard predicts every row result in Q16.16
// and compares it field by field. The gains are changed only when the block is
// idle.
// ----------------------------------------------------------------------------
import spmv_pkg::*;

class spmv_results;
   localparam int          FRAC     = 16;
   localparam logic [15:0] LAST_ROW = 16'hFFFF;

   logic signed [31:0] x_entry [1024];
   logic signed [63:0] row_sum = '0;
   logic [15:0]        row_num = '0;
   logic signed [31:0] alpha   = 32'sd65536;
   logic signed [31:0] beta    = '0;
   rsp_type            b_expected [$];
   int                 failures = 0;

   // Exact 32x32 product, magnitude rounded half away from zero.
   function logic signed [63:0] mul_round(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [63:0] p;
      logic [63:0]        m;
      p = a * b;
      m = p < 0 ? -p : p;
      m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
      return p < 0 ? -$signed(m) : $signed(m);
   endfunction

   // Gain times the 64-bit row sum, rounded, then clamped to the 64-bit range.
   function logic signed [63:0] scale_sum(logic signed [31:0] gain, logic signed [63:0] sum);
      logic signed [127:0] p;
      logic [127:0]        m;
      logic [127:0]        lim;
      bit                  neg;
      p = gain * sum;
      neg = p < 0;
      m = neg ? -p : p;
      m = (m + (128'd1 << (FRAC - 1))) >> FRAC;
      lim = neg ? 128'd1 << 63 : (128'd1 << 63) - 1;
      if (m > lim) m = lim;
      return neg ? -m[63:0] : m[63:0];
   endfunction

   function logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] s;
      s = a + b;
      if (s[64] != s[63]) return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      return s[63:0];
   endfunction

   function void set_gain(logic [CSR_INDEX_WIDTH-1:0] index, logic [31:0] data);
      case (index)
         CSR_ALPHA: alpha = data;
         CSR_BETA:  beta  = data;
         default: ;
      endcase
   endfunction

   function void close_row(logic signed [31:0] b_old);
      logic signed [63:0] total;
      rsp_type            e;
      total = sat_add(scale_sum(alpha, row_sum), mul_round(beta, b_old));
      if (total > 64'sd2147483647) total = 64'sd2147483647;
      else if (total < -64'sd2147483648) total = -64'sd2147483648;
      e.b_new     = total[31:0];
      e.row_index = row_num;
      b_expected.push_back(e);
      row_sum = '0;
      if (row_num != LAST_ROW) row_num++;
   endfunction

   function void note_request(req_type r);
      case (r.command)
         CMD_LOAD: begin
            x_entry[r.column] = r.value;
            row_num = '0;
         end
         CMD_NONZERO: begin
            row_sum = sat_add(row_sum, mul_round(r.value, x_entry[r.column]));
            if (r.row_end) close_row(r.b_old);
         end
         CMD_EMPTY_ROW: close_row(r.b_old);
         default: ;
      endcase
   endfunction

   function void check_result(rsp_type got);
      rsp_type e;
      if (b_expected.size() == 0) begin
         failures++;
         $error("result with no row pending: b_new %0d row_index %0d",
                got.b_new, got.row_index);
         return;
      end
      e = b_expected.pop_front();
      if (got.b_new !== e.b_new) begin
         failures++;
         $error("b_new mismatch on row %0d: expected %0d, actual %0d",
                e.row_index, e.b_new, got.b_new);
      end
      if (got.row_index !== e.row_index) begin
         failures++;
         $error("row_index mismatch: expected %0d, actual %0d",
                e.row_index, got.row_index);
      end
   endfunction

   function int pending();
      return b_expected.size();
   endfunction
endclass

module tb;

   // Command code 3 has no meaning; the block must drop it without a result.
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // A register index with nothing behind it; writes to it must change nothing.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE = 4'd15;

   localparam int RANDOM_ITEMS   = 850;
   localparam int PHASES         = 8;
   // Extra wait after the last result, covering work with no result pending.
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_push  = 1'b0;
   req_type                    req_data  = '0;
   logic                       req_full;
   logic                       rsp_empty;
   logic                       rsp_pop   = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0]                csr_data  = '0;

   spmv_results results;

   // When set, the matching side runs without any idle cycles.
   bit        req_steady = 1'b0;
   bit        rsp_steady = 1'b0;
   int        rsp_hold   = 0;
   int        quiet_cycles = 0;
   // Columns of x that have been loaded; nonzeros only ever read these.
   bit [9:0]  loaded_cols [$];

   csr_sparse_matrix_vector_multiply dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int gap_length();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 85) return $urandom_range(1, 3);
      if (k < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Q16.16 operand: the extremes, full-range noise, or a value within +-4.0
   // so that sums stay in range often enough to be interesting.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom;
         default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      endcase
   endfunction

   function automatic logic [9:0] pick_column();
      return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
   endfunction

   // Push one transaction, wait for it to be taken, then idle for a while.
   // The push stays high across back-to-back transactions, so push sees one
   // assignment per clock edge at most.
   task automatic push_item(req_type r);
      int gap;
      req_data <= r;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      results.note_request(r);
      gap = req_steady ? 0 : gap_length();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // The row-end flag and the old b value of a load are ignored, so they are
   // randomized to prove it.
   task automatic load_x(logic [9:0] col, logic [31:0] val);
      req_type r;
      r.command = CMD_LOAD;
      r.column  = col;
      r.value   = val;
      r.row_end = 1'($urandom_range(0, 1));
      r.b_old   = $urandom;
      push_item(r);
      loaded_cols.push_back(col);
   endtask

   task automatic nonzero(logic [9:0] col, logic [31:0] val, bit last, logic [31:0] b_old);
      req_type r;
      r.command = CMD_NONZERO;
      r.column  = col;
      r.value   = val;
      r.row_end = last;
      r.b_old   = b_old;
      push_item(r);
   endtask

   // Column, value and row-end flag of an empty row are don't-care fields.
   task automatic empty_row(logic [31:0] b_old);
      req_type r;
      r.command = CMD_EMPTY_ROW;
      r.column  = 10'($urandom_range(0, 1023));
      r.value   = $urandom;
      r.row_end = 1'($urandom_range(0, 1));
      r.b_old   = b_old;
      push_item(r);
   endtask

   task automatic unused_command();
      req_type r;
      r.command = CMD_UNUSED;
      r.column  = 10'($urandom_range(0, 1023));
      r.value   = $urandom;
      r.row_end = 1'($urandom_range(0, 1));
      r.b_old   = $urandom;
      push_item(r);
   endtask

   // Stop sending and wait until every predicted result has been popped, then
   // let the block finish any work that has no result attached.
   task automatic drain(int extra);
      req_push <= 1'b0;
      do @(posedge clock); while (results.pending() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] index, logic [31:0] data);
      csr_index <= index;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      results.set_gain(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: check each popped transaction, then choose the pop for the
   // next edge. A stall only ever begins after pop has been high.
   initial begin
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_pop <= 1'b0;
         end else begin
            if (rsp_pop && !rsp_empty) results.check_result(rsp_data);
            if (rsp_hold > 0) begin
               rsp_hold--;
               rsp_pop <= 1'b0;
            end else begin
               rsp_pop <= 1'b1;
               if (!rsp_steady) rsp_hold = gap_length();
            end
         end
      end
   end

   // Watchdog: any accepted transaction on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("[csr_sparse_matrix_vector_multiply] ERROR");
         $finish;
      end
   end

   initial begin
      logic [31:0] a_gain;
      logic [31:0] b_gain;
      int          sent;
      int          n;
      int          k;

      results = new;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, under the reset gains (alpha 1.0, beta 0).
      // Extreme x entries at both ends of the store, plus 1.0, 0.5 and -1 lsb.
      load_x(10'd0,    32'h7FFF_FFFF);
      load_x(10'd1023, 32'h8000_0000);
      load_x(10'd1,    32'h0001_0000);
      load_x(10'd2,    32'h0000_8000);
      load_x(10'd3,    32'hFFFF_FFFF);
      // Empty row right after reset: the accumulator is zero and beta is zero.
      empty_row(32'h7FFF_FFFF);
      // Rounding of exact halves goes away from zero on both signs.
      nonzero(10'd2, 32'h0000_0001, 1'b1, 32'h0);
      nonzero(10'd2, 32'hFFFF_FFFF, 1'b1, 32'h0);
      nonzero(10'd3, 32'h0000_8000, 1'b1, 32'h8000_0000);
      // Large positive sum that must clamp to the top of the 32-bit range.
      nonzero(10'd0,    32'h7FFF_FFFF, 1'b0, 32'h0);
      nonzero(10'd1023, 32'h8000_0000, 1'b0, 32'h0);
      nonzero(10'd0,    32'h7FFF_FFFF, 1'b1, 32'h8000_0000);
      // Large negative sum that must clamp to the bottom.
      nonzero(10'd1023, 32'h7FFF_FFFF, 1'b0, 32'h0);
      nonzero(10'd1023, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF);
      // An unterminated row survives a load, which restarts the row count; the
      // unused command code in between must leave everything alone.
      nonzero(10'd1, 32'h1234_5678, 1'b0, 32'h0);
      unused_command();
      load_x(10'd4, 32'hFFFE_8000);
      empty_row(32'h0);
      // A row of nonzeros closed by an empty row instead of the row-end flag.
      nonzero(10'd4, 32'h0003_0000, 1'b0, 32'h5555_5555);
      empty_row(32'hAAAA_AAAA);

      // Random part, split into phases with different gains. The gains change
      // only once all results are out and the block has gone quiet.
      for (int p = 0; p < PHASES; p++) begin
         drain(SETTLE_CYCLES);
         case (p)
            0: begin a_gain = 32'h0001_0000; b_gain = 32'h0001_0000; end
            1: begin a_gain = 32'h7FFF_FFFF; b_gain = 32'h8000_0000; end
            2: begin a_gain = 32'h8000_0000; b_gain = 32'h7FFF_FFFF; end
            3: begin a_gain = 32'h0000_0000; b_gain = 32'hFFFF_0000; end
            4: begin a_gain = 32'hFFFF_0000; b_gain = 32'h0000_0000; end
            5: begin a_gain = 32'h0001_8000; b_gain = 32'h0000_4000; end
            default: begin a_gain = $urandom; b_gain = $urandom; end
         endcase
         write_csr(CSR_ALPHA, a_gain);
         write_csr(CSR_BETA, b_gain);
         if (p == 3) write_csr(CSR_SPARE, $urandom);
         req_steady = (p == 1);
         rsp_steady = (p == 2);

         // Column 0 holds the largest x for the heavy rows below.
         load_x(10'd0, 32'h7FFF_FFFF);
         sent = 1;
         while (sent < RANDOM_ITEMS / PHASES) begin
            if ($urandom_range(0, 49) == 0) req_steady = !req_steady;
            if ($urandom_range(0, 49) == 0) rsp_steady = !rsp_steady;
            k = $urandom_range(0, 99);
            if (k < 8) begin
               load_x(10'($urandom_range(0, 1023)), pick_value());
               sent++;
            end else if (k < 12) begin
               unused_command();
            end else if (k < 14) begin
               // Hold the sender until every result has been popped.
               drain(0);
            end else if (k < 24) begin
               empty_row($urandom);
               sent++;
            end else if (k < 27) begin
               // Eight maximal products: under an extreme alpha this overflows
               // the 64-bit scaled sum before the final 32-bit clamp.
               for (int i = 0; i < 8; i++)
                  nonzero(10'd0, 32'h7FFF_FFFF, i == 7, $urandom);
               sent += 8;
            end else begin
               n = $urandom_range(1, 6);
               for (int i = 0; i < n; i++)
                  nonzero(pick_column(), pick_value(), i == n - 1, $urandom);
               sent += n;
            end
         end
      end

      req_steady = 1'b0;
      rsp_steady = 1'b0;

      drain(SETTLE_CYCLES);
      if (results.failures == 0 && results.pending() == 0)
         $display("[csr_sparse_matrix_vector_multiply] OK");
      else
         $display("[csr_sparse_matrix_vector_multiply] ERROR");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/spmv_pkg.sv
hw/rtl/spmv_ram.sv
hw/rtl/spmv_front.sv
hw/rtl/spmv_queue.sv
hw/rtl/spmv_back.sv
hw/rtl/csr_sparse_matrix_vector_multiply.sv
hw/rtl/spmv_checker.sv
test/tb.sv
